@@ hw/rtl/nau_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nau_pkg: shared types and constants of the activation unit
// Opcodes, the per-word context that rides the pipeline, and result limits.
// ----------------------------------------------------------------------------
package nau_pkg;

  localparam int DATA_W = 16;
  localparam int OP_W   = 3;

  // Codes 6 and 7 carry no meaning; they fall into the default arms.
  typedef enum logic [OP_W-1:0] {
    OP_RELU_FWD = 3'd0,
    OP_SIG_FWD  = 3'd1,
    OP_TANH_FWD = 3'd2,
    OP_RELU_BWD = 3'd3,
    OP_SIG_BWD  = 3'd4,
    OP_TANH_BWD = 3'd5
  } op_t;

  // Per-word context carried alongside the datapath.
  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] g;
  } ctx_t;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 16'sh8000;

endpackage
`default_nettype wire

@@ hw/rtl/neural_activation_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// neural_activation_unit: ReLU / sigmoid / tanh with backward derivatives
// Streaming element-wise activation in signed fixed point, one word a cycle.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata (low bit first)               | tuser
//  --------+-----------+-------------------------------------+----------------
//  in_     | slave     | [15:0] operand_x, [31:16] upstream_grad | [2:0] opcode
//  out_    | master    | [15:0] result_value                 | [0] saturated
//
//  One word enters per cycle while out_tready does not stall the pipe; a
//  result passes seven register stages (four interpolation, three
//  derivative/output; the accepting edge loads the first).
//  Every stage holds its own valid bit and moves when empty or when the stage
//  after it moves, so a stall at out_tready backs up only full stages and
//  bubbles are squeezed out.
//  Reset (rst_n low, synchronous) clears the valid bits only; no warm-up pass.
//  Sigmoid and tanh nodes are computed at elaboration into constant tables.
//
module neural_activation_unit #(
  parameter int TABLE_SEGMENTS = 64,
  parameter int FRAC_BITS      = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] operand_x, [31:16] upstream_grad
  input  logic [2:0]  in_tuser,   // [2:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] result_value
  output logic        out_tuser   // [0] saturated
);
  import nau_pkg::*;

  ctx_t                        in_ctx;
  ctx_t                        mid_ctx;
  logic                        mid_valid;
  logic                        mid_ready;
  logic signed [FRAC_BITS+1:0] mid_act;

  // Unpack the word into the context that follows it down the pipe.
  always_comb begin
    in_ctx.op = op_t'(in_tuser);
    in_ctx.x  = in_tdata[DATA_W-1:0];
    in_ctx.g  = in_tdata[2*DATA_W-1:DATA_W];
  end

  // Stages 1-4: clamp, index, node read, interpolate.
  nau_interp #(
    .TABLE_SEGMENTS (TABLE_SEGMENTS),
    .FRAC_BITS      (FRAC_BITS)
  ) u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_ctx    (in_ctx),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_ctx   (mid_ctx),
    .out_act   (mid_act)
  );

  // Stages 5-7: derivative, gradient product, select, saturate, output reg.
  nau_deriv #(
    .FRAC_BITS (FRAC_BITS)
  ) u_deriv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_ctx    (mid_ctx),
    .in_act    (mid_act),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_tdata),
    .out_sat   (out_tuser)
  );

endmodule
`default_nettype wire

@@ hw/rtl/nau_interp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nau_interp: table lookup with linear interpolation
// Four stages: clamp and index, node read, slope product, sum.
// ----------------------------------------------------------------------------
module nau_interp #(
  parameter int TABLE_SEGMENTS = 64,
  parameter int FRAC_BITS      = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  nau_pkg::ctx_t             in_ctx,
  output logic                      out_valid,
  input  logic                      out_ready,
  output nau_pkg::ctx_t             out_ctx,
  output logic signed [FRAC_BITS+1:0] out_act
);
  import nau_pkg::*;

  localparam int TW    = FRAC_BITS + 2;          // node / activation width
  localparam int NODES = TABLE_SEGMENTS + 1;
  localparam int SW    = $clog2(NODES);          // segment index width
  localparam int FW    = FRAC_BITS + 4;          // fraction width (span = 2^FW)
  localparam int PW    = FW + SW;
  localparam int XW    = FW + 1;
  localparam int CW    = ((FRAC_BITS + 5 > DATA_W) ? FRAC_BITS + 5 : DATA_W) + 1;
  localparam int MW    = TW + FW + 2;

  localparam logic signed [CW-1:0] LIM    = CW'(8 << FRAC_BITS);
  localparam logic signed [CW-1:0] NLIM   = -LIM;
  localparam logic [SW-1:0]        LAST   = SW'(TABLE_SEGMENTS);
  localparam logic [PW-1:0]        SEG_K  = PW'(TABLE_SEGMENTS);
  localparam logic signed [MW-1:0] HSPAN  = MW'(64'd1 << (FW - 1));
  localparam logic signed [TW-1:0] ONE_T  = TW'(1 << FRAC_BITS);
  localparam longint unsigned      Q30    = 64'd1 << 30;
  localparam longint unsigned      SEG64  = 64'(TABLE_SEGMENTS);

  // --- elaboration-time node generation (Q30 exponential) ------------------
  // Restoring long division, quotient only; used on constants alone.
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned exp_series(input longint unsigned r);
    longint unsigned term;
    longint          sum;
    term = Q30;
    sum  = longint'(Q30);
    for (int n = 1; n <= 24; n++) begin
      term = udiv((term * r) >> 30, 64'(n));
      if (n[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  function automatic longint unsigned exp_neg(input longint unsigned num);
    longint unsigned k;
    longint unsigned r;
    longint unsigned e;
    longint unsigned em1;
    k   = udiv(num, SEG64);
    r   = udiv((num - k * SEG64) << 30, SEG64);
    e   = exp_series(r);
    em1 = exp_series(Q30);
    for (longint unsigned j = 0; j < k; j++) begin
      e = (e * em1) >> 30;
    end
    return e;
  endfunction

  function automatic longint node_value(input logic is_tanh, input longint unsigned i);
    longint unsigned pos;
    longint unsigned mid;
    longint unsigned mag;
    longint unsigned half;
    longint unsigned e;
    longint unsigned v;
    logic            neg;
    pos  = 16 * i;
    mid  = 8 * SEG64;
    neg  = pos < mid;
    mag  = neg ? mid - pos : pos - mid;
    half = 64'd1 << (29 - FRAC_BITS);
    if (!is_tanh) begin
      e = exp_neg(mag);
      v = udiv(64'd1 << 60, Q30 + e);
      if (neg) v = Q30 - v;
      return longint'((v + half) >> (30 - FRAC_BITS));
    end
    e = exp_neg(2 * mag);
    v = udiv((Q30 - e) << 30, Q30 + e);
    v = (v + half) >> (30 - FRAC_BITS);
    return neg ? -longint'(v) : longint'(v);
  endfunction

  function automatic logic [NODES*TW-1:0] build_table(input logic is_tanh);
    logic [NODES*TW-1:0] tab;
    tab = '0;
    for (int i = 0; i < NODES; i++) begin
      tab[i*TW +: TW] = TW'(node_value(is_tanh, 64'(i)));
    end
    return tab;
  endfunction

  localparam logic [NODES*TW-1:0] SIG_TAB  = build_table(1'b0);
  localparam logic [NODES*TW-1:0] TANH_TAB = build_table(1'b1);

  // --- stage enables: a stage moves when empty or when its successor moves -
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // --- stage 1: clamp to [-8, 8], scale into segment and fraction ----------
  logic signed [CW-1:0] xs, xcl;
  logic [XW-1:0]        xc;
  logic [PW-1:0]        pos;
  ctx_t                 ctx1_r;
  logic [SW-1:0]        seg1_r;
  logic [FW-1:0]        frac1_r;

  always_comb begin
    xs  = {{(CW-DATA_W){in_ctx.x[DATA_W-1]}}, in_ctx.x};
    xcl = (xs > LIM) ? LIM : ((xs < NLIM) ? NLIM : xs);
    xc  = XW'(xcl + LIM);
    pos = PW'(xc) * SEG_K;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ctx1_r  <= in_ctx;
      seg1_r  <= pos[PW-1:FW];
      frac1_r <= pos[FW-1:0];
    end
  end

  // --- stage 2: read both bracketing nodes ---------------------------------
  logic [SW-1:0]        seg_hi;
  logic                 is_tanh;
  logic signed [TW-1:0] y0, y1;
  ctx_t                 ctx2_r;
  logic signed [TW-1:0] y02_r;
  logic signed [TW:0]   dy2_r;
  logic [FW-1:0]        frac2_r;

  always_comb begin
    // the last node has no right neighbor; its fraction is zero anyway
    seg_hi  = (seg1_r == LAST) ? seg1_r : seg1_r + 1'b1;
    is_tanh = (ctx1_r.op == OP_TANH_FWD) || (ctx1_r.op == OP_TANH_BWD);
    y0 = is_tanh ? TANH_TAB[seg1_r*TW +: TW] : SIG_TAB[seg1_r*TW +: TW];
    y1 = is_tanh ? TANH_TAB[seg_hi*TW +: TW] : SIG_TAB[seg_hi*TW +: TW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      ctx2_r  <= ctx1_r;
      y02_r   <= y0;
      dy2_r   <= {y1[TW-1], y1} - {y0[TW-1], y0};
      frac2_r <= frac1_r;
    end
  end

  // --- stage 3: slope times fraction ---------------------------------------
  ctx_t                 ctx3_r;
  logic signed [TW-1:0] y03_r;
  logic signed [MW-1:0] prod3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      ctx3_r  <= ctx2_r;
      y03_r   <= y02_r;
      prod3_r <= MW'(dy2_r) * MW'($signed({1'b0, frac2_r}));
    end
  end

  // --- stage 4: round by half a span, add to the left node -----------------
  logic signed [MW-1:0] step;
  ctx_t                 ctx4_r;
  logic signed [TW-1:0] act4_r;

  assign step = (prod3_r + HSPAN) >>> FW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      ctx4_r <= ctx3_r;
      act4_r <= y03_r + TW'(step);
    end
  end

  assign out_valid = v4_r;
  assign out_ctx   = ctx4_r;
  assign out_act   = act4_r;

  // --- checks ---------------------------------------------------------------
  a_last_node_no_frac : assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && (seg1_r == LAST) |-> frac1_r == '0)
    else $error("last segment carries a nonzero fraction");

  a_act_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (act4_r <= ONE_T) && (act4_r >= -ONE_T))
    else $error("interpolated activation outside [-1, 1]");

  a_sig_nonneg : assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && ((ctx4_r.op == OP_SIG_FWD) || (ctx4_r.op == OP_SIG_BWD)) |-> act4_r >= 0)
    else $error("sigmoid value below zero");

  a_stage2_hold : assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !en3 |=> v2_r && $stable(dy2_r) && $stable(y02_r))
    else $error("stalled node pair changed");

endmodule
`default_nettype wire

@@ hw/rtl/nau_deriv.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nau_deriv: derivative, gradient product, result select and saturation
// Three stages; the last one is the output register.
// ----------------------------------------------------------------------------
module nau_deriv #(
  parameter int FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  nau_pkg::ctx_t               in_ctx,
  input  logic signed [FRAC_BITS+1:0] in_act,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [nau_pkg::DATA_W-1:0]  out_value,
  output logic                        out_sat
);
  import nau_pkg::*;

  localparam int TW  = FRAC_BITS + 2;
  localparam int OW  = TW + 1;
  localparam int M1W = 2 * OW;
  localparam int P2W = DATA_W + OW;

  localparam logic signed [OW-1:0]  ONE_O  = OW'(1 << FRAC_BITS);
  localparam logic signed [M1W-1:0] HALF_M = M1W'(1 << (FRAC_BITS - 1));
  localparam logic signed [P2W-1:0] HALF_P = P2W'(1 << (FRAC_BITS - 1));
  localparam logic signed [P2W-1:0] MAX_P  = P2W'(SAT_MAX);
  localparam logic signed [P2W-1:0] MIN_P  = P2W'(SAT_MIN);

  logic v5_r, v6_r, v7_r;
  logic en5, en6, en7;

  assign en7      = !v7_r || out_ready;
  assign en6      = !v6_r || en7;
  assign en5      = !v5_r || en6;
  assign in_ready = en5;

  // --- stage 5: s*(1-s) for sigmoid, t*t for tanh --------------------------
  logic signed [OW-1:0]  act_e, rhs;
  ctx_t                  ctx5_r;
  logic signed [TW-1:0]  act5_r;
  logic signed [M1W-1:0] m5_r;

  always_comb begin
    act_e = {in_act[TW-1], in_act};
    rhs   = (in_ctx.op == OP_SIG_BWD) ? ONE_O - act_e : act_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en5) begin
      v5_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      ctx5_r <= in_ctx;
      act5_r <= in_act;
      m5_r   <= M1W'(act_e) * M1W'(rhs);
    end
  end

  // --- stage 6: round to the derivative, multiply by the gradient ----------
  logic signed [M1W-1:0] m_rnd;
  logic signed [OW-1:0]  deriv;
  ctx_t                  ctx6_r;
  logic signed [TW-1:0]  act6_r;
  logic signed [P2W-1:0] p6_r;

  always_comb begin
    m_rnd = (m5_r + HALF_M) >>> FRAC_BITS;
    deriv = (ctx5_r.op == OP_SIG_BWD) ? OW'(m_rnd) : ONE_O - OW'(m_rnd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en6) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      ctx6_r <= ctx5_r;
      act6_r <= act5_r;
      p6_r   <= P2W'(ctx5_r.g) * P2W'(deriv);
    end
  end

  // --- stage 7: pick the result, clip to 16 bits ---------------------------
  logic signed [P2W-1:0]    grad, res;
  logic                     x_pos;
  logic signed [DATA_W-1:0] val_nxt;
  logic                     sat_nxt;
  logic signed [DATA_W-1:0] val7_r;
  logic                     sat7_r;

  always_comb begin
    grad  = (p6_r + HALF_P) >>> FRAC_BITS;
    x_pos = !ctx6_r.x[DATA_W-1] && (|ctx6_r.x);
    case (ctx6_r.op)
      OP_RELU_FWD: res = x_pos ? P2W'(ctx6_r.x) : '0;
      OP_SIG_FWD:  res = P2W'(act6_r);
      OP_TANH_FWD: res = P2W'(act6_r);
      OP_RELU_BWD: res = x_pos ? P2W'(ctx6_r.g) : '0;
      OP_SIG_BWD:  res = grad;
      OP_TANH_BWD: res = grad;
      default:     res = '0;
    endcase
    if (res > MAX_P) begin
      val_nxt = SAT_MAX;
      sat_nxt = 1'b1;
    end else if (res < MIN_P) begin
      val_nxt = SAT_MIN;
      sat_nxt = 1'b1;
    end else begin
      val_nxt = DATA_W'(res);
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en7) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      val7_r <= val_nxt;
      sat7_r <= sat_nxt;
    end
  end

  assign out_valid = v7_r;
  assign out_value = val7_r;
  assign out_sat   = sat7_r;

  // --- checks ---------------------------------------------------------------
  a_sat_at_rail : assert property (@(posedge clk) disable iff (!rst_n)
    v7_r && sat7_r |-> (val7_r == SAT_MAX) || (val7_r == SAT_MIN))
    else $error("saturation flag set off the rails");

  a_relu_no_sat : assert property (@(posedge clk) disable iff (!rst_n)
    en7 && v6_r && ((ctx6_r.op == OP_RELU_FWD) || (ctx6_r.op == OP_RELU_BWD))
    |=> !sat7_r)
    else $error("relu result flagged as saturated");

  a_stage6_hold : assert property (@(posedge clk) disable iff (!rst_n)
    v6_r && !en7 |=> v6_r && $stable(p6_r))
    else $error("stalled gradient product changed");

endmodule
`default_nettype wire
